FILE: src/imuca_pkg.sv
// ----------------------------------------------------------------------------
// imuca_pkg
// Shared types and constants for the complementary attitude filter core.
// ----------------------------------------------------------------------------
package imuca_pkg;

	localparam int CNT_W       = 6;
	localparam int ATAN_LEN    = 24;
	localparam int SQRT_STEPS  = 24;
	localparam int RAD_W       = 48;
	localparam int GP_W        = 34;
	localparam int ST_W        = 32;
	localparam int OUT_W       = 25;
	localparam int PROD_W      = 43;
	localparam int DIVISOR     = 125;

	localparam logic [32:0] GRAV_LO = 33'd136771184;
	localparam logic [32:0] GRAV_HI = 33'd628030946;
	localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
	localparam logic [16:0] WEIGHT_RESET = 17'd65405;

	// configuration register indexes
	localparam logic [1:0] REG_BIAS_X = 2'd0;
	localparam logic [1:0] REG_BIAS_Y = 2'd1;
	localparam logic [1:0] REG_BIAS_Z = 2'd2;
	localparam logic [1:0] REG_WEIGHT = 2'd3;

	// atan(2^-i) in degrees, 24 fraction bits
	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000934, 32'd30029717, 32'd15018523, 32'd7509720,
		32'd3754917, 32'd1877466, 32'd938734, 32'd469367,
		32'd234684, 32'd117342, 32'd58671, 32'd29335,
		32'd14668, 32'd7334, 32'd3667, 32'd1833,
		32'd917, 32'd458, 32'd229, 32'd115
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP1,
		ST_PREP2,
		ST_PREP3,
		ST_ITER,
		ST_CLOAD,
		ST_CORD,
		ST_ANGLE,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             load;
		logic             prep1;
		logic             prep2;
		logic             prep3;
		logic             iter;
		logic             cload;
		logic             cord;
		logic             angle;
		logic             mul;
		logic             commit;
		logic [CNT_W-1:0] cnt;
	} dp_cmd_t;

endpackage

FILE: src/imuca_ctrl.sv
// ----------------------------------------------------------------------------
// imuca_ctrl
// Sequencer for one sample: prepare, root and divide, cordic, blend, commit.
// ----------------------------------------------------------------------------
module imuca_ctrl import imuca_pkg::*; #(
	parameter int CORDIC_STEPS    = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t cmd
);

	localparam int ITER_N = SQRT_STEPS;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             mvalid_q, mvalid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			mvalid_q <= mvalid_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		cmd.cnt    = cnt_q;
		s_tready   = (state_q == ST_IDLE);
		mvalid_d   = mvalid_q && !m_tready;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP1;
				end
			end
			ST_PREP1: begin
				cmd.prep1 = 1'b1;
				state_d   = ST_PREP2;
			end
			ST_PREP2: begin
				cmd.prep2 = 1'b1;
				state_d   = ST_PREP3;
			end
			ST_PREP3: begin
				cmd.prep3 = 1'b1;
				cnt_d     = '0;
				state_d   = ST_ITER;
			end
			ST_ITER: begin
				cmd.iter = 1'b1;
				if (cnt_q == CNT_W'(ITER_N - 1)) begin
					cnt_d   = '0;
					state_d = ST_CLOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_CLOAD: begin
				cmd.cload = 1'b1;
				cnt_d     = '0;
				state_d   = ST_CORD;
			end
			ST_CORD: begin
				cmd.cord = 1'b1;
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_ANGLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ANGLE: begin
				cmd.angle = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// wait until the output register is free
				if (!mvalid_q || m_tready) begin
					cmd.commit = 1'b1;
					mvalid_d   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = mvalid_q;

endmodule

FILE: src/imuca_datapath.sv
// ----------------------------------------------------------------------------
// imuca_datapath
// Squares, integer roots, rate dividers, two cordic lanes, blend and wrap.
// ----------------------------------------------------------------------------
module imuca_datapath import imuca_pkg::*; #(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dp_cmd_t       cmd,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [23:0]   cfg_data,
	input  logic [119:0]  s_tdata,
	input  logic          s_tuser,
	output logic [79:0]   m_tdata,
	output logic          m_tuser
);

	localparam int K      = 28 - ANGLE_FRAC_BITS;
	localparam int DIV_W  = 14 + ANGLE_FRAC_BITS;
	localparam int SH     = 24 - ANGLE_FRAC_BITS;
	localparam int CX_W   = 28;
	localparam int S_R    = DIV_W + 7;
	localparam int RC_W   = DIV_W + 1;
	localparam int MUL_W  = DIV_W + RC_W;
	localparam logic [RC_W-1:0] RECIP =
		RC_W'(((64'd1 << S_R) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
	localparam logic [41:0] HALF_DEN = 42'(DIVISOR) << (K - 1);
	localparam logic signed [GP_W-1:0] HALF = GP_W'(180) << ANGLE_FRAC_BITS;
	localparam logic signed [GP_W-1:0] FULL = GP_W'(360) << ANGLE_FRAC_BITS;
	localparam logic signed [32:0] RND = 33'(1) << (SH - 1);

	function automatic logic signed [GP_W-1:0] wrap(input logic signed [GP_W-1:0] v);
		logic signed [GP_W-1:0] r;
		r = v;
		if (v > HALF)
			r = v - FULL;
		else if (v < -HALF)
			r = v + FULL;
		return r;
	endfunction

	// configuration
	logic signed [23:0] bias_q [3];
	logic [16:0]        weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q[0] <= '0;
			bias_q[1] <= '0;
			bias_q[2] <= '0;
			weight_q  <= WEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIAS_X: bias_q[0] <= cfg_data;
				REG_BIAS_Y: bias_q[1] <= cfg_data;
				REG_BIAS_Z: bias_q[2] <= cfg_data;
				REG_WEIGHT: weight_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// filter state
	logic signed [ST_W-1:0] filt_q [3];
	logic signed [ST_W-1:0] held_q [2];

	// sample capture
	logic               rcmd_q;
	logic signed [15:0] acc_q [3];
	logic signed [15:0] gyr_q [3];
	logic [19:0]        dt_q;

	// prepare stages
	logic [31:0]               sq_s1 [3];
	logic signed [24:0]        rq_s1 [3];
	logic [16:0]               dt_s1;
	logic                      valid_q;
	logic [RAD_W-1:0]          rad_s2 [2];
	logic signed [PROD_W-1:0]  prod_s2 [3];

	// iterative units
	logic [RAD_W-1:0]   sn_q [2];
	logic [RAD_W-1:0]   sr_q [2];
	logic [RAD_W-1:0]   sbit_q;
	logic [DIV_W-1:0]   dq_q [3];
	logic               neg_q [3];

	// cordic lanes
	logic signed [CX_W-1:0] cx_q [2];
	logic signed [CX_W-1:0] cy_q [2];
	logic signed [31:0]     cz_q [2];

	logic signed [GP_W-1:0] gp_q [3];
	logic signed [51:0]     pg_s1 [2];
	logic signed [51:0]     pa_s1 [2];

	logic [OUT_W-1:0] out_q [3];
	logic             outv_q;

	logic [16:0] w_sat;
	logic [16:0] w_acc;
	assign w_sat = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	assign w_acc = WEIGHT_ONE - w_sat;

	// final angle for lane i: blend and realign (lanes 0 and 1), then wrap; cmd selects the held angle or zero
	function automatic logic signed [GP_W-1:0] sel_ang(input int i);
		logic signed [51:0]     s;
		logic signed [GP_W-1:0] v;
		v = gp_q[i];
		if (i < 2) begin
			s = pg_s1[i] + pa_s1[i] + 52'sd32768;
			if (valid_q)
				v = GP_W'(s >>> 16);
		end
		v = wrap(v);
		if (rcmd_q) begin
			if (i < 2)
				v = GP_W'(held_q[i]);
			else
				v = '0;
		end
		return v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) filt_q[i] <= '0;
			held_q[0] <= '0;
			held_q[1] <= '0;
		end else begin
			if (cmd.angle && valid_q) begin
				for (int i = 0; i < 2; i++)
					held_q[i] <= ST_W'((33'(cz_q[i]) + RND) >>> SH);
			end
			if (cmd.commit) begin
				for (int i = 0; i < 3; i++) filt_q[i] <= ST_W'(sel_ang(i));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rcmd_q   <= s_tuser;
			acc_q[0] <= s_tdata[15:0];
			acc_q[1] <= s_tdata[31:16];
			acc_q[2] <= s_tdata[47:32];
			gyr_q[0] <= s_tdata[63:48];
			gyr_q[1] <= s_tdata[79:64];
			gyr_q[2] <= s_tdata[95:80];
			dt_q     <= s_tdata[115:96];
		end
		if (cmd.prep1) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= 32'(acc_q[i] * acc_q[i]);
				rq_s1[i] <= {gyr_q[i][15], gyr_q[i], 8'b0} - {bias_q[i][23], bias_q[i]};
			end
			if (dt_q < 20'd100)
				dt_s1 <= 17'd100;
			else if (dt_q > 20'd100000)
				dt_s1 <= 17'd100000;
			else
				dt_s1 <= dt_q[16:0];
		end
		if (cmd.prep2) begin
			valid_q <= ((33'(sq_s1[0]) + 33'(sq_s1[1]) + 33'(sq_s1[2])) > GRAV_LO) &&
				((33'(sq_s1[0]) + 33'(sq_s1[1]) + 33'(sq_s1[2])) < GRAV_HI);
			rad_s2[0] <= {sq_s1[2] + sq_s1[0], 16'b0};
			rad_s2[1] <= {sq_s1[2] + sq_s1[1], 16'b0};
			for (int i = 0; i < 3; i++)
				prod_s2[i] <= PROD_W'(rq_s1[i] * $signed({1'b0, dt_s1}));
		end
		if (cmd.prep3) begin
			for (int i = 0; i < 3; i++) begin
				logic [41:0] mag;
				logic [41:0] t;
				mag       = prod_s2[i][PROD_W-1] ? 42'(-prod_s2[i]) : 42'(prod_s2[i]);
				t         = mag + HALF_DEN;
				dq_q[i]   <= t[41:K];
				neg_q[i]  <= prod_s2[i][PROD_W-1];
			end
			for (int i = 0; i < 2; i++) begin
				sn_q[i] <= rad_s2[i];
				sr_q[i] <= '0;
			end
			sbit_q <= RAD_W'(1) << (2 * SQRT_STEPS - 2);
		end
		if (cmd.iter) begin
			if (cmd.cnt < CNT_W'(SQRT_STEPS)) begin
				for (int i = 0; i < 2; i++) begin
					if (sn_q[i] >= sr_q[i] + sbit_q) begin
						sn_q[i] <= sn_q[i] - (sr_q[i] + sbit_q);
						sr_q[i] <= (sr_q[i] >> 1) + sbit_q;
					end else begin
						sr_q[i] <= sr_q[i] >> 1;
					end
				end
				sbit_q <= sbit_q >> 2;
			end
			// divide by the odd part of the rate scale, reciprocal multiply
			// exact for every dividend below 2^DIV_W
			if (cmd.cnt == '0) begin
				for (int i = 0; i < 3; i++) begin
					logic [MUL_W-1:0] qp;
					qp      = MUL_W'(dq_q[i]) * MUL_W'(RECIP);
					dq_q[i] <= DIV_W'(qp >> S_R);
				end
			end
		end
		if (cmd.cload) begin
			cx_q[0] <= CX_W'(sr_q[0]);
			cx_q[1] <= CX_W'(sr_q[1]);
			cy_q[0] <= CX_W'($signed({acc_q[1], 8'b0}));
			cy_q[1] <= -CX_W'($signed({acc_q[0], 8'b0}));
			cz_q[0] <= '0;
			cz_q[1] <= '0;
		end
		if (cmd.cord) begin
			for (int i = 0; i < 2; i++) begin
				logic signed [CX_W-1:0] dx;
				logic signed [CX_W-1:0] dy;
				dx = cx_q[i] >>> cmd.cnt[4:0];
				dy = cy_q[i] >>> cmd.cnt[4:0];
				if (cy_q[i] > 0) begin
					cx_q[i] <= cx_q[i] + dy;
					cy_q[i] <= cy_q[i] - dx;
					cz_q[i] <= cz_q[i] + $signed(ATAN_TAB[cmd.cnt[4:0]]);
				end else begin
					cx_q[i] <= cx_q[i] - dy;
					cy_q[i] <= cy_q[i] + dx;
					cz_q[i] <= cz_q[i] - $signed(ATAN_TAB[cmd.cnt[4:0]]);
				end
			end
		end
		if (cmd.angle) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [GP_W-1:0] d;
				d = GP_W'($signed({1'b0, dq_q[i]}));
				gp_q[i] <= GP_W'(filt_q[i]) + (neg_q[i] ? -d : d);
			end
		end
		if (cmd.mul) begin
			for (int i = 0; i < 2; i++) begin
				pg_s1[i] <= 52'(gp_q[i] * $signed({1'b0, w_sat}));
				pa_s1[i] <= 52'(held_q[i] * $signed({1'b0, w_acc}));
			end
		end
		if (cmd.commit) begin
			for (int i = 0; i < 3; i++) out_q[i] <= OUT_W'(sel_ang(i));
			outv_q <= valid_q;
		end
	end

	assign m_tdata = {5'b0, out_q[2], out_q[1], out_q[0]};
	assign m_tuser = outv_q;

endmodule

FILE: src/imu_complementary_attitude_core.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude_core
// Roll, pitch and yaw complementary filter for one raw 6-axis sample.
//
//  channel  dir  payload
//  s_*      in   tdata: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
//                elapsed_us; tuser: cmd
//  m_*      out  tdata: roll_deg, pitch_deg, yaw_deg; tuser: accel_valid
//  cfg_*    in   register index and data, one write per cycle
//
// A sample passes the prepare steps, the bit-serial integer roots and then the
// cordic lanes before its result is committed to the output register. One
// sample is in work at a time; s_tready is high when the sequencer is idle,
// also while a result waits in the output register.
// A held result only delays the commit of the next one.
// Reset clears the angles and the bias registers and sets the weight to 65405.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_core import imuca_pkg::*; #(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, elapsed_us
	input  logic         s_tuser,  // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,  // roll_deg, pitch_deg, yaw_deg
	output logic         m_tuser,  // accel_valid
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	dp_cmd_t cmd;

	imuca_ctrl #(
		.CORDIC_STEPS    (CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	imuca_datapath #(
		.CORDIC_STEPS    (CORDIC_STEPS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
